// ----- sv/xmrf_pkg.sv -----
// xmrf_pkg: shared types and constants for the xmodem receiver to flash
// no dependencies
package xmrf_pkg;

  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_HASH = 8'h23;

  localparam logic [2:0] REG_APP_BASE    = 3'd0;
  localparam logic [2:0] REG_APP_LIMIT   = 3'd1;
  localparam logic [2:0] REG_RAM_BASE    = 3'd2;
  localparam logic [2:0] REG_RAM_SPAN    = 3'd3;
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd4;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_RERR = 2'd3;

  // one result item
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        wr_valid;
    logic [31:0] wr_addr;
    logic [31:0] wr_data;
    logic [1:0]  status;
    logic        last;
  } res_t;

  // classified action passed from front to back
  typedef struct packed {
    logic        has_a;
    res_t        a;
    logic        has_b;
    res_t        b;
  } act_t;

endpackage

// ----- sv/xmrf_front.sv -----
// xmrf_front: protocol state machine, classifies each byte into up to two results
// depends on xmrf_pkg
module xmrf_front import xmrf_pkg::*; #(
  parameter int PACKET_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] app_base,
  input  logic [31:0] app_limit,
  input  logic [31:0] ram_base,
  input  logic [31:0] ram_span,
  input  logic [2:0]  retry_limit,
  output act_t        act
);

  localparam int CW = $clog2(PACKET_BYTES + 2);
  localparam logic [CW-1:0] WHOLE = CW'((PACKET_BYTES / 4) * 4);
  localparam logic [CW-1:0] LASTB = CW'(PACKET_BYTES + 1);

  localparam logic [2:0] PH_IDLE = 3'd0, PH_HEADER = 3'd1, PH_NUM = 3'd2,
                         PH_COMP = 3'd3, PH_DATA = 3'd4, PH_DRAIN = 3'd5,
                         PH_DONE = 3'd6;

  logic [2:0]    phase_r, phase_nxt;
  logic [7:0]    exp_r, exp_nxt, prev_r, prev_nxt, hdr_r, hdr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    retry_r, retry_nxt;
  logic [23:0]   gath_r, gath_nxt;
  logic [31:0]   waddr_r, waddr_nxt, sp_r, sp_nxt, rv_r, rv_nxt;
  logic          dack_r, dack_nxt;
  logic [1:0]    fst_r, fst_nxt;

  logic [31:0] word, addr;
  logic [32:0] sp_top;
  logic        sp_ok, rv_ok;
  res_t        ra, rb;
  logic        ha, hb;

  assign word   = {rx_byte, gath_r};
  assign addr   = waddr_r + 32'({cnt_r[CW-1:2], 2'b00});
  assign sp_top = {1'b0, ram_base} + {1'b0, ram_span};
  assign sp_ok  = (sp_r >= ram_base) && ({1'b0, sp_r} <= sp_top);
  assign rv_ok  = (rv_r >= app_base) && (rv_r < app_limit);

  always_comb begin
    phase_nxt = phase_r; exp_nxt = exp_r; prev_nxt = prev_r; hdr_nxt = hdr_r;
    cnt_nxt = cnt_r; retry_nxt = retry_r; gath_nxt = gath_r; waddr_nxt = waddr_r;
    sp_nxt = sp_r; rv_nxt = rv_r; dack_nxt = dack_r; fst_nxt = fst_r;
    ra = '0; rb = '0; ha = 1'b0; hb = 1'b0;
    if (opcode) begin
      exp_nxt = 8'd1; prev_nxt = '0; hdr_nxt = '0; cnt_nxt = '0; retry_nxt = '0;
      gath_nxt = '0; waddr_nxt = app_base; sp_nxt = '0; rv_nxt = '0;
      dack_nxt = 1'b0; fst_nxt = ST_RUN; phase_nxt = PH_HEADER;
      ha = 1'b1; ra.tx_valid = 1'b1; ra.tx_byte = CH_NAK;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (rx_byte == CH_EOT) begin
            ha = 1'b1; ra.tx_valid = 1'b1; ra.tx_byte = CH_ACK;
            fst_nxt = (sp_ok && rv_ok) ? ST_OK : ST_BAD;
            phase_nxt = PH_DONE;
          end else if (rx_byte == CH_SOH) begin
            phase_nxt = PH_NUM;
          end else if (retry_r >= retry_limit) begin
            fst_nxt = ST_RERR; phase_nxt = PH_DONE; ha = 1'b1;
          end else begin
            retry_nxt = retry_r + 3'd1;
            ha = 1'b1; ra.tx_valid = 1'b1; ra.tx_byte = CH_NAK;
          end
        end
        PH_NUM: begin
          hdr_nxt = rx_byte; phase_nxt = PH_COMP;
        end
        PH_COMP: begin
          cnt_nxt = '0; gath_nxt = '0;
          if (hdr_r == exp_r && rx_byte == ~exp_r) begin
            phase_nxt = PH_DATA;
          end else begin
            dack_nxt = (hdr_r == prev_r); phase_nxt = PH_DRAIN;
          end
        end
        PH_DATA: begin
          if (cnt_r < WHOLE) begin
            case (cnt_r[1:0])
              2'd0: gath_nxt[7:0]   = rx_byte;
              2'd1: gath_nxt[15:8]  = rx_byte;
              2'd2: gath_nxt[23:16] = rx_byte;
              default: begin
                if (addr == app_base) sp_nxt = word;
                if (addr == app_base + 32'd4) rv_nxt = word;
                gath_nxt = '0;
                ha = 1'b1; ra.wr_valid = 1'b1; ra.wr_addr = addr; ra.wr_data = word;
              end
            endcase
          end
          if (cnt_r >= LASTB) begin
            // ack lands in slot a (no write on this byte)
            ha = 1'b1; ra.tx_valid = 1'b1; ra.tx_byte = CH_ACK;
            prev_nxt = hdr_r; exp_nxt = exp_r + 8'd1;
            waddr_nxt = waddr_r + 32'(PACKET_BYTES);
            if (exp_nxt[2:0] == 3'd0) begin
              hb = 1'b1; rb.tx_valid = 1'b1; rb.tx_byte = CH_HASH;
            end
            cnt_nxt = '0; phase_nxt = PH_HEADER;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        PH_DRAIN: begin
          if (cnt_r >= LASTB) begin
            ha = 1'b1; ra.tx_valid = 1'b1; ra.tx_byte = dack_r ? CH_ACK : CH_NAK;
            cnt_nxt = '0; phase_nxt = PH_HEADER;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
    ra.status = (phase_nxt == PH_DONE) ? fst_nxt : ST_RUN;
    rb.status = ra.status;
    ra.last = ~hb;
    rb.last = 1'b1;
    act.has_a = ha; act.a = ra; act.has_b = hb; act.b = rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; exp_r <= 8'd1; prev_r <= '0; hdr_r <= '0; cnt_r <= '0;
      retry_r <= '0; gath_r <= '0; waddr_r <= 32'h4000; sp_r <= '0; rv_r <= '0;
      dack_r <= 1'b0; fst_r <= ST_RUN;
    end else if (step) begin
      phase_r <= phase_nxt; exp_r <= exp_nxt; prev_r <= prev_nxt; hdr_r <= hdr_nxt;
      cnt_r <= cnt_nxt; retry_r <= retry_nxt; gath_r <= gath_nxt;
      waddr_r <= waddr_nxt; sp_r <= sp_nxt; rv_r <= rv_nxt; dack_r <= dack_nxt;
      fst_r <= fst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n && step) begin
      assert (!(act.has_b && !act.has_a))
        else $error("second result without first");
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && !(step && opcode)) |=> phase_r == PH_DONE)
    else $error("left done without start");
  a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_HEADER && !opcode && retry_r >= retry_limit &&
     rx_byte != CH_EOT && rx_byte != CH_SOH) |-> act.a.status == ST_RERR)
    else $error("retry error not flagged");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LASTB)
    else $error("byte count overrun");

endmodule

// ----- sv/xmrf_queue.sv -----
// xmrf_queue: result queue between front and back, pushes up to two results a cycle
// depends on xmrf_pkg
module xmrf_queue import xmrf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  act_t act,
  output logic room,
  output logic empty,
  input  logic pop,
  output res_t head
);

  localparam int DEPTH = 4;
  res_t       mem_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_pop;
  logic [1:0] nin;

  assign empty  = (cnt_r == 3'd0);
  assign do_pop = pop && !empty;
  // room for two results, counting a pop in the same cycle
  assign room   = (cnt_r <= 3'd2) || (cnt_r == 3'd3 && pop);
  assign head   = mem_r[rp_r];
  assign nin    = push ? ({1'b0, act.has_a} + {1'b0, act.has_b}) : 2'd0;
  assign cnt_nxt = cnt_r + {1'b0, nin} - {2'b0, do_pop};

  always_ff @(posedge clk) begin
    if (push && act.has_a) mem_r[wp_r] <= act.a;
    if (push && act.has_b) mem_r[wp_r + 2'd1] <= act.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + nin;
      rp_r  <= rp_r + {1'b0, do_pop};
      cnt_r <= cnt_nxt;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("queue overflow");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && nin == 2'd0) |=> cnt_r == $past(cnt_r) - 3'd1)
    else $error("pop miscounted");
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !room) |-> 1'b0) else $error("push without room");

endmodule

// ----- sv/xmodem_receive_to_flash.sv -----
// xmodem_receive_to_flash: top level, config registers, front state machine and result queue
// depends on xmrf_pkg, xmrf_front, xmrf_queue
// results: a byte's results enter the queue when it is accepted and reach the out ports from its head
// throughput: one byte per cycle while full is low; full rises only while the four-entry queue lacks room for two
// reset: rst_n synchronous active low, registers back to their defaults, state idle
// config writes take effect at the next edge and are meant while the block is quiet
module xmodem_receive_to_flash import xmrf_pkg::*; #(
  parameter int PACKET_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_wr_valid,
  output logic [31:0] out_wr_addr,
  output logic [31:0] out_wr_data,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] app_base_r, app_limit_r, ram_base_r, ram_span_r;
  logic [2:0]  retry_limit_r;
  logic        room, step;
  act_t        act;
  res_t        head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_base_r <= 32'h4000; app_limit_r <= 32'h80000;
      ram_base_r <= 32'h2000_0000; ram_span_r <= 32'h20000; retry_limit_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_APP_BASE:    app_base_r    <= cfg_data;
        REG_APP_LIMIT:   app_limit_r   <= cfg_data;
        REG_RAM_BASE:    ram_base_r    <= cfg_data;
        REG_RAM_SPAN:    ram_span_r    <= cfg_data;
        REG_RETRY_LIMIT: retry_limit_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign full = !room;
  assign step = push && room;

  // front: classifies each byte
  xmrf_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
    .clk, .rst_n, .step, .opcode(in_opcode), .rx_byte(in_rx_byte),
    .app_base(app_base_r), .app_limit(app_limit_r), .ram_base(ram_base_r),
    .ram_span(ram_span_r), .retry_limit(retry_limit_r), .act
  );

  // back: result queue towards the consumer
  xmrf_queue u_queue (
    .clk, .rst_n, .push(step), .act, .room, .empty, .pop, .head
  );

  assign out_tx_valid = head.tx_valid;
  assign out_tx_byte  = head.tx_byte;
  assign out_wr_valid = head.wr_valid;
  assign out_wr_addr  = head.wr_addr;
  assign out_wr_data  = head.wr_data;
  assign out_status   = head.status;
  assign out_last     = head.last;

endmodule
